// ===== rtl/core/mhpq_pkg.sv =====
// Shared constants, codes and controller/datapath types for the max-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              accept_push;
        logic              accept_pop;
        logic              pop_load;
        logic              up_step;
        logic              down_step;
        logic              capture;
        logic [STAT_W-1:0] result_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic up_done;
        logic down_done;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] parent_idx(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        q = p - IDX_W'(1);
        return q >> 1;
    endfunction

endpackage

// ===== rtl/core/mhpq_ifs.sv =====
// Valid/ready channel interfaces for the request and result beats.
interface mhpq_cmd_if;
    import mhpq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic signed [KEY_W-1:0] item_value;

    modport source (output valid, output operation, output item_value, input ready);
    modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface mhpq_res_if;
    import mhpq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] popped_value;
    logic signed [KEY_W-1:0] top_value;
    logic [CNT_W-1:0]        entry_total;

    modport source (output valid, output status, output popped_value, output top_value,
                    output entry_total, input ready);
    modport sink   (input valid, input status, input popped_value, input top_value,
                    input entry_total, output ready);
endinterface

// ===== rtl/core/mhpq_ctrl.sv =====
// Sequencing controller for push, pop and the sift walks of the heap.
module mhpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_operation,
    output logic               in_ready,
    input  mhpq_pkg::dp_stat_t stat,
    output mhpq_pkg::dp_cmd_t  cmd
);
    import mhpq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_POPLD  = 3'd2;
    localparam logic [2:0] S_DOWN   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              fire;

    assign in_ready = (state_reg == S_IDLE);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        state_next         = state_reg;
        status_next        = status_reg;
        cmd                = '0;
        cmd.result_status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    cmd.accept  = 1'b1;
                    status_next = ST_OK;
                    if (in_operation == OP_PUSH)
                    begin
                        if (stat.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            cmd.accept_push = 1'b1;
                            state_next      = S_UP;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            cmd.accept_pop = 1'b1;
                            state_next     = S_POPLD;
                        end
                    end
                end
            end
            S_UP:
            begin
                cmd.up_step = 1'b1;
                if (stat.up_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_POPLD:
            begin
                // The count was already decremented; a heap left empty needs no sift.
                if (stat.empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.pop_load = 1'b1;
                    state_next   = S_DOWN;
                end
            end
            S_DOWN:
            begin
                cmd.down_step = 1'b1;
                if (stat.down_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    a_push_full_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_operation == OP_PUSH && stat.full) |=> (status_reg == ST_FULL))
        else $error("full push not flagged");

    a_pop_empty_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_operation == OP_POP && stat.empty) |=> (status_reg == ST_EMPTY))
        else $error("empty pop not flagged");

    a_sift_ends_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN && stat.down_done) |=> (state_reg == S_FIN))
        else $error("sift down did not finish");

endmodule

// ===== rtl/core/mhpq_dp.sv =====
// Heap store, sift compare logic, entry count and result register.
module mhpq_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mhpq_pkg::dp_cmd_t                 cmd,
    output mhpq_pkg::dp_stat_t                stat,
    input  logic signed [mhpq_pkg::KEY_W-1:0] item_value,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [mhpq_pkg::STAT_W-1:0]       out_status,
    output logic signed [mhpq_pkg::KEY_W-1:0] out_popped,
    output logic signed [mhpq_pkg::KEY_W-1:0] out_top,
    output logic [mhpq_pkg::CNT_W-1:0]        out_total
);
    import mhpq_pkg::*;

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] top_reg;
    logic signed [KEY_W-1:0] popped_reg, popped_next;
    logic signed [KEY_W-1:0] rd_a, rd_b;
    logic                    out_valid_reg;

    logic [IDX_W:0]          lc;
    logic [IDX_W+1:0]        rc;
    logic                    l_gt, r_gt, up_move;
    logic signed [KEY_W-1:0] cand;
    logic                    we;
    logic signed [KEY_W-1:0] wdata;
    logic [IDX_W-1:0]        addr_a, addr_b;
    logic [CNT_W-1:0]        cnt_m1;
    logic [IDX_W:0]          lc_next;
    logic [IDX_W+1:0]        rc_next;

    assign lc      = {pos_reg, 1'b1};
    assign rc      = {1'b0, lc} + (IDX_W+2)'(1);
    assign up_move = (pos_reg != '0) && (rd_a < key_reg);
    assign l_gt    = ({1'b0, lc} < (IDX_W+2)'(count_reg)) && (rd_a > key_reg);
    assign cand    = l_gt ? rd_a : key_reg;
    assign r_gt    = (rc < (IDX_W+2)'(count_reg)) && (rd_b > cand);
    assign cnt_m1  = count_reg - CNT_W'(1);

    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.up_done   = !up_move;
    assign stat.down_done = !(l_gt || r_gt);
    assign stat.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        popped_next = popped_reg;
        we          = 1'b0;
        wdata       = key_reg;
        if (cmd.accept)
        begin
            popped_next = '0;
        end
        if (cmd.accept_push)
        begin
            key_next   = item_value;
            pos_next   = count_reg[IDX_W-1:0];
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.accept_pop)
        begin
            popped_next = top_reg;
            count_next  = cnt_m1;
        end
        if (cmd.pop_load)
        begin
            key_next = rd_a;
            pos_next = '0;
        end
        if (cmd.up_step)
        begin
            // Hole method: the parent moves down and the new key lands where it stops.
            we = 1'b1;
            if (up_move)
            begin
                wdata    = rd_a;
                pos_next = parent_idx(pos_reg);
            end
        end
        if (cmd.down_step)
        begin
            we = 1'b1;
            if (r_gt)
            begin
                wdata    = rd_b;
                pos_next = rc[IDX_W-1:0];
            end
            else if (l_gt)
            begin
                wdata    = rd_a;
                pos_next = lc[IDX_W-1:0];
            end
        end
    end

    // Reads for the next step are issued from the next hole position.
    assign lc_next = {pos_next, 1'b1};
    assign rc_next = {1'b0, lc_next} + (IDX_W+2)'(1);

    always_comb
    begin
        if (cmd.accept_pop)
        begin
            addr_a = cnt_m1[IDX_W-1:0];
        end
        else if (cmd.pop_load || cmd.down_step)
        begin
            addr_a = lc_next[IDX_W-1:0];
        end
        else
        begin
            addr_a = parent_idx(pos_next);
        end
        addr_b = rc_next[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[pos_reg] <= wdata;
        end
        rd_a <= mem[addr_a];
        rd_b <= mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        popped_reg <= popped_next;
        if (we && pos_reg == '0)
        begin
            top_reg <= wdata;
        end
        if (cmd.capture)
        begin
            out_status <= cmd.result_status;
            out_popped <= popped_reg;
            out_top    <= (count_reg != '0) ? top_reg : '0;
            out_total  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ({1'b0, pos_reg} < count_reg))
        else $error("write outside the occupied heap");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept_pop |-> (count_reg != '0))
        else $error("pop issued on empty heap");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

endmodule

// ===== rtl/core/max_heap_priority_queue.sv =====
// Max-heap priority queue of signed 32-bit keys: top level.
//
// Usage: request beats arrive on cmd (operation 0 pushes item_value,
// operation 1 pops the largest key). Each request yields exactly one result
// beat on res carrying status, the popped key, the new top key and the entry
// count. Requests are taken one at a time; cmd.ready is high while idle, so a
// new request can be taken as soon as the previous result is registered.
// A push walks its key up through the sift-up state and a pop loads the last
// key and walks it down through the sift-down state, one heap level per
// cycle through a single-write, dual-read store, before the finish state.
// A pop of the last key skips the sift, and a push on a full heap or a pop on
// an empty one goes straight to the finish state.
// A finished result sits in an output register, so the next request is
// accepted while it waits; if res stays stalled the following request stops
// in its finish state until the register frees. Reset empties the queue at
// once; store contents need no clearing since only occupied slots are used.
module max_heap_priority_queue (
    input  logic       clk,
    input  logic       rst_n,
    mhpq_cmd_if.sink   cmd,
    mhpq_res_if.source res
);
    import mhpq_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    mhpq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd.valid),
        .in_operation (cmd.operation),
        .in_ready     (cmd.ready),
        .stat         (dp_stat),
        .cmd          (dp_cmd)
    );

    mhpq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .item_value (cmd.item_value),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .out_status (res.status),
        .out_popped (res.popped_value),
        .out_top    (res.top_value),
        .out_total  (res.entry_total)
    );

endmodule
